[hw/rtl/block_padding_inserter_core_macros.svh]
// Assertion macros shared by the block padding inserter RTL.
// Define NO_ASSERTIONS to compile the macros away; no other dependencies.
`ifndef BLOCK_PADDING_INSERTER_CORE_MACROS_SVH
`define BLOCK_PADDING_INSERTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check with reset disable and a fixed failure message.
`define PBI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pbi assertion failed");
// Clocked check with reset disable and a caller-supplied message.
`define PBI_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define PBI_ASSERT(lbl, clk, rst_n, prop)
`define PBI_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif
`endif

[hw/rtl/pbi_pkg.sv]
// Package for the block padding inserter: payload and control types, constants
// and the LFSR step function. No dependencies.
`default_nettype none
package pbi_pkg;

  localparam int MAX_BLOCK_DEF = 32;
  localparam int BLOCK_SIZE_W  = 6;
  localparam int PAD_MODE_W    = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_BYTE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd3;

  // Pad mode codes.
  localparam logic [PAD_MODE_W-1:0] PAD_ZERO   = 3'd0;
  localparam logic [PAD_MODE_W-1:0] PAD_ANSI   = 3'd1;
  localparam logic [PAD_MODE_W-1:0] PAD_ISO    = 3'd2;
  localparam logic [PAD_MODE_W-1:0] PAD_PKCS7  = 3'd3;
  localparam logic [PAD_MODE_W-1:0] PAD_CUSTOM = 3'd4;

  // Register reset values.
  localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 6'd8;
  localparam logic [PAD_MODE_W-1:0]   PAD_MODE_RST   = PAD_ZERO;
  localparam logic [7:0]              PAD_BYTE_RST   = 8'h01;
  localparam logic [15:0]             SEED_RST       = 16'h0001;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } pbi_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_pad;
    logic       final_byte;
  } pbi_out_t;

  typedef struct packed {
    logic [BLOCK_SIZE_W-1:0] block_size;
    logic [PAD_MODE_W-1:0]   pad_mode;
    logic [7:0]              pad_byte;
    logic [15:0]             random_seed;
  } pbi_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic emit_pad;
  } pbi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic pad_last;
  } pbi_sts_t;

  // One step of the Galois LFSR.
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pbi_cfg_regs.sv]
// Configuration registers of the block padding inserter.
// Depends on pbi_pkg for the register indexes and reset values.
`default_nettype none
module pbi_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pbi_pkg::CFG_DATA_W-1:0] cfg_data,
  output pbi_pkg::pbi_cfg_t                   cfg
);
  import pbi_pkg::*;

  pbi_cfg_t cfg_r;
  pbi_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:  cfg_nxt.block_size  = cfg_data[BLOCK_SIZE_W-1:0];
        CFG_PAD_MODE:    cfg_nxt.pad_mode    = cfg_data[PAD_MODE_W-1:0];
        CFG_PAD_BYTE:    cfg_nxt.pad_byte    = cfg_data[7:0];
        CFG_RANDOM_SEED: cfg_nxt.random_seed = cfg_data[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size  <= BLOCK_SIZE_RST;
      cfg_r.pad_mode    <= PAD_MODE_RST;
      cfg_r.pad_byte    <= PAD_BYTE_RST;
      cfg_r.random_seed <= SEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[hw/rtl/pbi_ctrl.sv]
// Controller state machine of the block padding inserter: accepts items and
// sequences the padding tail. Depends on pbi_pkg and the assertion macros.
`default_nettype none
`include "block_padding_inserter_core_macros.svh"
module pbi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              message_end,
  input  wire pbi_pkg::pbi_sts_t sts,
  output logic                   in_ready,
  output pbi_pkg::pbi_cmd_t      cmd
);
  import pbi_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_PAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.emit_pad = 1'b0;
    state_nxt    = state_r;
    case (state_r)
      S_IDLE: begin
        // A new item is taken whenever the output register can take its byte.
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && message_end) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.emit_pad = sts.out_free;
        if (sts.out_free && sts.pad_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PBI_ASSERT(a_end_starts_pad, clk, rst_n, (cmd.accept && message_end) |=> (state_r == S_PAD))
  `PBI_ASSERT(a_last_pad_ends, clk, rst_n, (cmd.emit_pad && sts.pad_last) |=> (state_r == S_IDLE))
  `PBI_ASSERT_MSG(a_no_accept_in_pad, clk, rst_n, (state_r == S_PAD) |-> !cmd.accept, "item taken during padding")

endmodule
`default_nettype wire

[hw/rtl/pbi_datapath.sv]
// Datapath of the block padding inserter: block position, LFSR, pad counter
// and output register. Depends on pbi_pkg and the assertion macros.
`default_nettype none
`include "block_padding_inserter_core_macros.svh"
module pbi_datapath #(
  parameter int MAX_BLOCK = pbi_pkg::MAX_BLOCK_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbi_pkg::pbi_in_t  in_data,
  input  wire pbi_pkg::pbi_cfg_t cfg,
  input  wire pbi_pkg::pbi_cmd_t cmd,
  input  wire logic              out_ready,
  output pbi_pkg::pbi_sts_t      sts,
  output logic                   out_valid,
  output pbi_pkg::pbi_out_t      out_data
);
  import pbi_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int EXT_W = (CNT_W > BLOCK_SIZE_W) ? CNT_W : BLOCK_SIZE_W;

  logic [CNT_W-1:0] block_position_r, block_position_nxt;
  logic [CNT_W-1:0] pad_remaining_r, pad_remaining_nxt;
  logic [CNT_W-1:0] pad_len_r, pad_len_nxt;
  logic [15:0]      lfsr_r, lfsr_nxt;
  logic             message_started_r, message_started_nxt;
  logic             out_valid_r, out_valid_nxt;
  pbi_out_t         out_r, out_nxt;

  logic [EXT_W-1:0] bs_ext;
  logic [CNT_W-1:0] bs;
  logic [CNT_W-1:0] pos_base;
  logic [CNT_W:0]   pos_inc;
  logic [CNT_W-1:0] pos_after;
  logic [15:0]      lfsr_adv;
  logic [7:0]       pad_value;
  logic             pad_last;

  // Block size clamped to 1..MAX_BLOCK.
  always_comb begin
    bs_ext = EXT_W'(cfg.block_size);
    if (bs_ext == '0) begin
      bs = CNT_W'(1);
    end else if (bs_ext > EXT_W'(MAX_BLOCK)) begin
      bs = CNT_W'(MAX_BLOCK);
    end else begin
      bs = bs_ext[CNT_W-1:0];
    end
  end

  // A fresh message starts aligned; so does a position left beyond a lowered block size.
  always_comb begin
    if (!message_started_r || (block_position_r >= bs)) begin
      pos_base = '0;
    end else begin
      pos_base = block_position_r;
    end
    pos_inc = {1'b0, pos_base} + (CNT_W + 1)'(1);
    if (!in_data.byte_present) begin
      pos_after = pos_base;
    end else if (pos_inc >= {1'b0, bs}) begin
      pos_after = '0;
    end else begin
      pos_after = pos_inc[CNT_W-1:0];
    end
  end

  assign pad_last = (pad_remaining_r == CNT_W'(1));
  assign lfsr_adv = lfsr_step(lfsr_r);

  always_comb begin
    case (cfg.pad_mode)
      PAD_ANSI:   pad_value = pad_last ? 8'(pad_len_r) : 8'h00;
      PAD_ISO:    pad_value = lfsr_adv[7:0];
      PAD_PKCS7:  pad_value = 8'(pad_len_r);
      PAD_CUSTOM: pad_value = cfg.pad_byte;
      default:    pad_value = 8'h00;
    endcase
  end

  always_comb begin
    block_position_nxt  = block_position_r;
    pad_remaining_nxt   = pad_remaining_r;
    pad_len_nxt         = pad_len_r;
    lfsr_nxt            = lfsr_r;
    message_started_nxt = message_started_r;
    out_nxt             = out_r;
    out_valid_nxt       = out_valid_r && !out_ready;

    // Items with neither a byte nor an end mark leave all state untouched.
    if (cmd.accept && (in_data.byte_present || in_data.message_end)) begin
      if (!message_started_r) begin
        lfsr_nxt = (cfg.random_seed == 16'h0000) ? 16'h0001 : cfg.random_seed;
      end
      if (in_data.byte_present) begin
        out_nxt.out_byte   = in_data.data_byte;
        out_nxt.is_pad     = 1'b0;
        out_nxt.final_byte = 1'b0;
        out_valid_nxt      = 1'b1;
      end
      if (in_data.message_end) begin
        pad_remaining_nxt   = bs - pos_after;
        pad_len_nxt         = bs - pos_after;
        block_position_nxt  = '0;
        message_started_nxt = 1'b0;
      end else begin
        block_position_nxt  = pos_after;
        message_started_nxt = 1'b1;
      end
    end

    if (cmd.emit_pad) begin
      if (cfg.pad_mode == PAD_ISO) begin
        lfsr_nxt = lfsr_adv;
      end
      out_nxt.out_byte   = pad_value;
      out_nxt.is_pad     = 1'b1;
      out_nxt.final_byte = pad_last;
      out_valid_nxt      = 1'b1;
      pad_remaining_nxt  = pad_remaining_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_position_r  <= '0;
      pad_remaining_r   <= '0;
      lfsr_r            <= 16'h0001;
      message_started_r <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      block_position_r  <= block_position_nxt;
      pad_remaining_r   <= pad_remaining_nxt;
      lfsr_r            <= lfsr_nxt;
      message_started_r <= message_started_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_len_r <= pad_len_nxt;
    out_r     <= out_nxt;
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.pad_last = pad_last;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  `PBI_ASSERT(a_final_is_pad, clk, rst_n, (out_valid_r && out_r.final_byte) |-> out_r.is_pad)
  `PBI_ASSERT_MSG(a_pad_count_live, clk, rst_n, cmd.emit_pad |-> (pad_remaining_r != '0), "pad emitted with no count left")
  `PBI_ASSERT(a_pos_in_range, clk, rst_n, message_started_r |-> (block_position_r < CNT_W'(MAX_BLOCK)))

endmodule
`default_nettype wire

[hw/rtl/block_padding_inserter_core.sv]
// Top level of the block padding inserter: configuration registers, controller
// and datapath. Depends on pbi_pkg, pbi_cfg_regs, pbi_ctrl and pbi_datapath.
//
// Use: message bytes enter on the in_ channel (valid/ready), one item per byte.
// An item with byte_present set passes its byte through; an item with
// message_end set closes the message and is followed by 1 to block_size pad
// bytes, a full block when the message is aligned or empty. An item with
// neither flag is dropped without any result.
// Results leave on the out_ channel (valid/ready) from a single output
// register; final_byte marks the last pad byte of a message.
// A passed byte appears on the output in the cycle after its item is accepted.
// Throughput: one item per cycle for bytes within a message while out_ready
// is high; after an item that ends the message, in_ready stays low while the
// pad sequencer emits one pad byte per cycle until the last pad byte is out.
// When the receiver stalls, the output register holds its item and in_ready
// drops, so nothing is lost; the pad sequence resumes when out_ready returns.
// Reset (synchronous, rst_n low) restores register defaults (block size 8, zero
// padding, pad byte 1, seed 1), empties the output and clears the position.
// Configuration must be written on cfg_ while idle; the block does not check.
`default_nettype none
module block_padding_inserter_core #(
  parameter int MAX_BLOCK = pbi_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire pbi_pkg::pbi_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pbi_pkg::pbi_out_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [pbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pbi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pbi_pkg::*;

  pbi_cfg_t cfg;
  pbi_cmd_t cmd;
  pbi_sts_t sts;

  pbi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The controller only decides when items are taken and pads are emitted.
  pbi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .message_end (in_data.message_end),
    .sts         (sts),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  // The datapath tracks block position, LFSR and pad count, and owns the
  // output register.
  pbi_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[tb/tb_block_padding_inserter_core.sv]
// Self-checking testbench for block_padding_inserter_core: directed and random
// messages against a padding predictor kept in a small checker class.
// Depends on pbi_pkg and block_padding_inserter_core; no other files.
module tb_block_padding_inserter_core;
  import pbi_pkg::*;

  // Pad mode codes that the block does not define; they must pad with zeros.
  localparam logic [PAD_MODE_W-1:0] PAD_UNDEF_LO = 3'd5;
  localparam logic [PAD_MODE_W-1:0] PAD_UNDEF_HI = 3'd7;
  // Block size codes that are out of range and must be clamped.
  localparam logic [BLOCK_SIZE_W-1:0] BS_CODE_ZERO = 6'd0;
  localparam logic [BLOCK_SIZE_W-1:0] BS_CODE_TOP  = 6'd63;

  // Cycles to wait after the last expected item before touching the registers;
  // the block answers in the cycle after an accepted item, so this wait is plenty.
  localparam int SETTLE_CYCLES = 4;
  // Cycles in a row without a transfer on either channel before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  // Number of message items (ignored items do not count) before the run stops.
  localparam int ITEM_TARGET   = 180;
  // From this many items on, neither side idles any more.
  localparam int QUIET_FROM    = 145;

  // Keeps its own copy of the registers and of the block state, predicts the
  // padded byte stream for every accepted item and checks the block's output
  // against it in order.
  class pad_stream_checker;
    logic [BLOCK_SIZE_W-1:0] block_size;
    logic [PAD_MODE_W-1:0]   pad_mode;
    logic [7:0]              pad_byte;
    logic [15:0]             random_seed;
    int unsigned             position;
    logic [15:0]             lfsr;
    bit                      in_message;
    pbi_out_t                expected_bytes[$];
    int                      errors;

    function new();
      block_size  = BLOCK_SIZE_RST;
      pad_mode    = PAD_MODE_RST;
      pad_byte    = PAD_BYTE_RST;
      random_seed = SEED_RST;
      position    = 0;
      lfsr        = 16'h0001;
      in_message  = 1'b0;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_BLOCK_SIZE:  block_size  = value[BLOCK_SIZE_W-1:0];
        CFG_PAD_MODE:    pad_mode    = value[PAD_MODE_W-1:0];
        CFG_PAD_BYTE:    pad_byte    = value[7:0];
        CFG_RANDOM_SEED: random_seed = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Works out the bytes that one accepted item causes.
    function void absorb_item(pbi_in_t it);
      int unsigned blk;
      int unsigned len;
      int unsigned rem;
      logic [7:0]  b;
      pbi_out_t    r;
      if (!it.byte_present && !it.message_end) return;
      blk = (block_size == 0) ? 1 : block_size;
      if (blk > MAX_BLOCK_DEF) blk = MAX_BLOCK_DEF;
      // The random source restarts from the seed at each message start;
      // a zero seed would lock the LFSR, so it becomes one.
      if (!in_message) begin
        lfsr       = (random_seed == 16'h0000) ? 16'h0001 : random_seed;
        position   = 0;
        in_message = 1'b1;
      end
      // A block size lowered mid-message leaves the position past the end;
      // it then counts as aligned.
      if (position >= blk) position = 0;
      if (it.byte_present) begin
        r.out_byte   = it.data_byte;
        r.is_pad     = 1'b0;
        r.final_byte = 1'b0;
        expected_bytes.push_back(r);
        position = (position + 1 >= blk) ? 0 : position + 1;
      end
      if (!it.message_end) return;
      len = blk - position;
      for (rem = len; rem > 0; rem--) begin
        case (pad_mode)
          PAD_ANSI:   b = (rem == 1) ? 8'(len) : 8'h00;
          PAD_ISO: begin
            lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
            b    = lfsr[7:0];
          end
          PAD_PKCS7:  b = 8'(len);
          PAD_CUSTOM: b = pad_byte;
          default:    b = 8'h00;
        endcase
        r.out_byte   = b;
        r.is_pad     = 1'b1;
        r.final_byte = (rem == 1);
        expected_bytes.push_back(r);
      end
      position   = 0;
      in_message = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_output(pbi_out_t got);
      pbi_out_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected item byte=%02h pad=%b final=%b",
                         got.out_byte, got.is_pad, got.final_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.is_pad !== want.is_pad)
        report($sformatf("is_pad %b, expected %b", got.is_pad, want.is_pad));
      if (got.final_byte !== want.final_byte)
        report($sformatf("final_byte %b, expected %b", got.final_byte, want.final_byte));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pbi_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pbi_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pad_stream_checker sb;
  // Chance of an idle burst is one in (idle_rate + 1); zero turns idling off.
  int idle_rate = 0;
  int items_sent = 0;
  int stall_left = 0;
  int quiet_count = 0;

  block_padding_inserter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver side. An item is taken at an edge where out_valid and out_ready
  // were both high; both are read here before any update of this edge lands.
  // Stalls come in bursts while idling is enabled; turning
  // idling off also cuts a burst that is still running.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_output(out_data);
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (rst_n && idle_rate != 0 && $urandom_range(0, idle_rate) == 0) begin
      stall_left = $urandom_range(1, 13);
    end
    out_ready <= (stall_left == 0) || (idle_rate == 0);
  end

  // The run is hung when nothing moves on either channel for too long.
  initial begin : watchdog
    while (quiet_count < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one item and returns at the edge where the block takes it. An idle
  // burst may come first; valid then drops until the item is offered.
  task automatic send_item(input logic [7:0] data, input logic present, input logic closes);
    pbi_in_t it;
    it = {data, present, closes};
    if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.absorb_item(it);
    if (present || closes) items_sent++;
  endtask

  // Sends a message body of nbytes bytes with an occasional ignored item in
  // between. When closes is set, the message ends on its last byte, or on a
  // separate end marker if use_marker is set or the message is empty.
  task automatic send_message(input int nbytes, input bit closes, input bit use_marker);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, closes && !use_marker && i == nbytes - 1);
    end
    if (closes && (use_marker || nbytes == 0)) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Holds the sender back until every predicted byte has come out, then lets
  // the block settle so that the registers may be written.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic apply_config(input logic [BLOCK_SIZE_W-1:0] bs, input logic [PAD_MODE_W-1:0] mode,
                              input logic [7:0] pbyte, input logic [15:0] seed);
    put_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bs));
    put_reg(CFG_PAD_MODE, CFG_DATA_W'(mode));
    put_reg(CFG_PAD_BYTE, CFG_DATA_W'(pbyte));
    put_reg(CFG_RANDOM_SEED, seed);
    cfg_we <= 1'b0;
  endtask

  // Random settings; block size, pad byte and seed lean toward their extremes.
  task automatic random_config();
    logic [BLOCK_SIZE_W-1:0] bs;
    logic [PAD_MODE_W-1:0]   mode;
    logic [7:0]              pbyte;
    logic [15:0]             seed;
    case ($urandom_range(0, 7))
      0:       bs = BS_CODE_ZERO;
      1:       bs = BS_CODE_TOP;
      2:       bs = BLOCK_SIZE_W'(MAX_BLOCK_DEF);
      3:       bs = 6'd1;
      4:       bs = BLOCK_SIZE_W'($urandom_range(MAX_BLOCK_DEF + 1, 63));
      default: bs = BLOCK_SIZE_W'($urandom_range(1, 12));
    endcase
    mode  = PAD_MODE_W'($urandom_range(PAD_ZERO, PAD_UNDEF_HI));
    case ($urandom_range(0, 3))
      0:       pbyte = 8'h00;
      1:       pbyte = 8'hFF;
      default: pbyte = 8'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       seed = 16'h0000;
      1:       seed = 16'hFFFF;
      default: seed = 16'($urandom);
    endcase
    apply_config(bs, mode, pbyte, seed);
  endtask

  initial begin : stimulus
    int  nmsg;
    int  len;
    bit  leave_open;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idle_rate = 3;

    // Reset settings: block of 8, zero padding. An ignored item, then an
    // empty message that must produce one whole block of padding, then a
    // short message with the byte extremes.
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b1, 1'b1);
    wait_drained();

    // Block size zero acts as one, so every message is aligned and gets a
    // full block of ANSI padding.
    apply_config(BS_CODE_ZERO, PAD_ANSI, 8'h00, 16'h0000);
    send_item(8'h81, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    wait_drained();

    // Oversized block code saturates to the largest block; ISO padding with a
    // zero seed, which the LFSR replaces by one.
    apply_config(BS_CODE_TOP, PAD_ISO, 8'hFF, 16'h0000);
    send_item(8'h3C, 1'b0, 1'b1);
    send_item(8'hC3, 1'b1, 1'b1);
    wait_drained();

    // PKCS7 on the largest block, message closed by an end marker with no byte.
    apply_config(BLOCK_SIZE_W'(MAX_BLOCK_DEF), PAD_PKCS7, 8'h55, 16'hFFFF);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hE7, 1'b0, 1'b1);
    wait_drained();

    // Custom pad byte on an aligned message.
    apply_config(6'd2, PAD_CUSTOM, 8'hFF, 16'h8001);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h34, 1'b1, 1'b1);
    wait_drained();

    // Unknown pad mode; the block size is lowered in the middle of a message,
    // which leaves the position beyond the new block end.
    apply_config(6'd16, PAD_UNDEF_LO, 8'hAA, 16'h1234);
    for (int i = 0; i < 6; i++) send_item(8'($urandom), 1'b1, 1'b0);
    wait_drained();
    apply_config(6'd4, PAD_UNDEF_HI, 8'hAA, 16'h1234);
    send_item(8'h99, 1'b1, 1'b1);
    wait_drained();

    // Random phases: new settings, then a few messages, mostly well formed.
    // A phase may leave its last message open so that it carries on under
    // the next settings.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) begin
        idle_rate = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_rate = 0;
          1:       idle_rate = 2;
          default: idle_rate = 7;
        endcase
      end
      random_config();
      nmsg = $urandom_range(1, 4);
      for (int m = 0; m < nmsg; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        leave_open = (m == nmsg - 1) && ($urandom_range(0, 4) == 0);
        send_message(len, !leave_open, $urandom_range(0, 3) == 0);
      end
      // Pressure: the sender holds off until the block has emptied.
      wait_drained();
    end

    // Close any message still open so that every state ends at rest.
    send_item(8'($urandom), 1'b0, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected items never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pbi_pkg.sv
hw/rtl/pbi_cfg_regs.sv
hw/rtl/pbi_ctrl.sv
hw/rtl/pbi_datapath.sv
hw/rtl/block_padding_inserter_core.sv
tb/tb_block_padding_inserter_core.sv
